// File: sv/pipc_pkg.sv
// Package for the point-in-polygon crossing unit: widths and register indexes.
package pipc_pkg;

    // Default coordinate width, Q16.16.
    localparam int PIPC_COORD_W = 32;

    // Configuration register index width and register indexes.
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_POINT_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_Y = 1'b1;

endpackage

// File: sv/point_in_polygon_crossing_unit.sv
// Point-in-polygon crossing-number unit, streamed one polygon vertex per item.
//
//   channel  direction  handshake                 payload
//   cfg      in         i_cfg_we                  i_cfg_idx, i_cfg_data
//   vertex   in         i_in_valid / o_in_stall   i_vertex_x, i_vertex_y, i_is_last
//   result   out        o_out_valid / i_out_stall o_inside_res
//
// One vertex item per cycle while o_in_stall is low. Each item passes an input
// register, a difference stage, a partial-product stage, a product-sum stage
// and the parity/result register: the inside flag of a polygon is written to
// the result register when its last vertex leaves stage 4.
// Reset (synchronous, active low) clears the test point, the polygon state and
// all stage valids. A stalled result stays in the result register; items keep
// entering until a last vertex waits in stage 4 behind it and stages 1 to 3 are
// full, then o_in_stall rises.
module point_in_polygon_crossing_unit #(
    parameter int COORD_WIDTH = pipc_pkg::PIPC_COORD_W
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pipc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]         i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [COORD_WIDTH-1:0]         i_vertex_x,
    input  logic [COORD_WIDTH-1:0]         i_vertex_y,
    input  logic                           i_is_last,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_inside_res
);
    import pipc_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;          // coordinate difference
    localparam int PW = 2 * DW;         // exact product
    localparam int H  = DW / 2;         // low half of a split operand
    localparam int HW = DW - H;         // signed high half

    typedef struct {
        logic signed [2*HW-1:0] hh;
        logic signed [HW+H:0]   hl;
        logic signed [HW+H:0]   lh;
        logic [2*H-1:0]         ll;
    } t_pp;

    typedef struct packed {
        logic act;
        logic up;
    } t_eflag;

    // Split product: four narrow multipliers instead of one wide one.
    function automatic t_pp pp_split(input logic signed [DW-1:0] a,
                                     input logic signed [DW-1:0] b);
        logic signed [HW-1:0] ah;
        logic signed [HW-1:0] bh;
        logic [H-1:0]         al;
        logic [H-1:0]         bl;
        logic signed [H:0]    als;
        logic signed [H:0]    bls;
        t_pp                  r;
        ah    = a[DW-1:H];
        bh    = b[DW-1:H];
        al    = a[H-1:0];
        bl    = b[H-1:0];
        als   = {1'b0, al};
        bls   = {1'b0, bl};
        r.hh  = ah * bh;
        r.hl  = ah * bls;
        r.lh  = als * bh;
        r.ll  = al * bl;
        return r;
    endfunction

    function automatic logic signed [PW-1:0] pp_sum(input t_pp p);
        logic signed [PW-1:0] t_hh;
        logic signed [PW-1:0] t_hl;
        logic signed [PW-1:0] t_lh;
        logic signed [PW-1:0] t_ll;
        t_hh = PW'(p.hh);
        t_hl = PW'(p.hl);
        t_lh = PW'(p.lh);
        t_ll = $signed(PW'(p.ll));
        return (t_hh <<< (2 * H)) + ((t_hl + t_lh) <<< H) + t_ll;
    endfunction

    // Configuration and polygon state
    logic signed [W-1:0] r_point_x;
    logic signed [W-1:0] r_point_y;
    logic signed [W-1:0] r_first_x;
    logic signed [W-1:0] r_first_y;
    logic signed [W-1:0] r_prev_x;
    logic signed [W-1:0] r_prev_y;
    logic                r_have_first;
    logic                r_parity;

    // Stage 1: edge endpoints
    logic                r1_v;
    logic                r1_last;
    logic                r1_have;
    logic signed [W-1:0] r1_vx;
    logic signed [W-1:0] r1_vy;
    logic signed [W-1:0] r1_px;
    logic signed [W-1:0] r1_py;
    logic signed [W-1:0] r1_fx;
    logic signed [W-1:0] r1_fy;

    // Stage 2: differences
    logic                 r2_v;
    logic                 r2_last;
    t_eflag               r2_f [2];
    logic signed [DW-1:0] r2_d [2][4];

    // Stage 3: partial products
    logic                 r3_v;
    logic                 r3_last;
    t_eflag               r3_f [2];
    t_pp                  r3_pp [2][2];

    // Stage 4: full products
    logic                 r4_v;
    logic                 r4_last;
    t_eflag               r4_f [2];
    logic signed [PW-1:0] r4_p [2][2];

    // Result register
    logic r_out_valid;
    logic r_inside;

    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy4;
    logic out_rdy;
    logic consume4;
    logic in_acc;

    logic signed [W-1:0]  c_ax [2];
    logic signed [W-1:0]  c_ay [2];
    logic signed [W-1:0]  c_bx [2];
    logic signed [W-1:0]  c_by [2];
    logic                 c_en [2];
    logic signed [DW-1:0] c_d [2][4];
    t_eflag               c_f [2];
    logic [1:0]           c_tog;
    logic                 c_flip;

    // Flow control: a stage takes a new item when it is empty or moving on.
    // A non-last item leaves stage 4 without needing the result register.
    assign out_rdy  = !r_out_valid || !i_out_stall;
    assign rdy4     = !r4_v || !r4_last || out_rdy;
    assign consume4 = r4_v && rdy4;
    assign rdy3     = !r3_v || rdy4;
    assign rdy2     = !r2_v || rdy3;
    assign rdy1     = !r1_v || rdy2;
    assign in_acc   = i_in_valid && rdy1;

    assign o_in_stall   = !rdy1;
    assign o_out_valid  = r_out_valid;
    assign o_inside_res = r_inside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_x <= '0;
            r_point_y <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_POINT_X: r_point_x <= $signed(i_cfg_data);
                REG_POINT_Y: r_point_y <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Polygon bookkeeping at the input
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_first <= 1'b0;
        end else if (in_acc) begin
            r_have_first <= !i_is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (!r_have_first) begin
                r_first_x <= $signed(i_vertex_x);
                r_first_y <= $signed(i_vertex_y);
            end
            r_prev_x <= $signed(i_vertex_x);
            r_prev_y <= $signed(i_vertex_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (rdy1) begin
            r1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_last <= i_is_last;
            r1_have <= r_have_first;
            r1_vx   <= $signed(i_vertex_x);
            r1_vy   <= $signed(i_vertex_y);
            r1_px   <= r_prev_x;
            r1_py   <= r_prev_y;
            // a lone vertex closes onto itself
            r1_fx   <= r_have_first ? r_first_x : $signed(i_vertex_x);
            r1_fy   <= r_have_first ? r_first_y : $signed(i_vertex_y);
        end
    end

    // Edge 0: previous vertex to this one. Edge 1: closing edge on the last vertex.
    always_comb begin
        c_ax[0] = r1_px;
        c_ay[0] = r1_py;
        c_bx[0] = r1_vx;
        c_by[0] = r1_vy;
        c_en[0] = r1_have;
        c_ax[1] = r1_vx;
        c_ay[1] = r1_vy;
        c_bx[1] = r1_fx;
        c_by[1] = r1_fy;
        c_en[1] = r1_last;
        for (int e = 0; e < 2; e++) begin
            c_d[e][0]  = DW'(r_point_x) - DW'(c_ax[e]);
            c_d[e][1]  = DW'(c_by[e]) - DW'(c_ay[e]);
            c_d[e][2]  = DW'(r_point_y) - DW'(c_ay[e]);
            c_d[e][3]  = DW'(c_bx[e]) - DW'(c_ax[e]);
            c_f[e].up  = (c_ay[e] <= r_point_y) && (c_by[e] > r_point_y);
            c_f[e].act = c_en[e] && (c_f[e].up ||
                         ((c_ay[e] > r_point_y) && (c_by[e] <= r_point_y)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (rdy2) begin
                r2_v <= r1_v;
            end
            if (rdy3) begin
                r3_v <= r2_v;
            end
            if (rdy4) begin
                r4_v <= r3_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_last <= r1_last;
            for (int e = 0; e < 2; e++) begin
                r2_f[e] <= c_f[e];
                for (int k = 0; k < 4; k++) begin
                    r2_d[e][k] <= c_d[e][k];
                end
            end
        end
        if (rdy3) begin
            r3_last <= r2_last;
            for (int e = 0; e < 2; e++) begin
                r3_f[e]     <= r2_f[e];
                r3_pp[e][0] <= pp_split(r2_d[e][0], r2_d[e][1]);
                r3_pp[e][1] <= pp_split(r2_d[e][2], r2_d[e][3]);
            end
        end
        if (rdy4) begin
            r4_last <= r3_last;
            for (int e = 0; e < 2; e++) begin
                r4_f[e]    <= r3_f[e];
                r4_p[e][0] <= pp_sum(r3_pp[e][0]);
                r4_p[e][1] <= pp_sum(r3_pp[e][1]);
            end
        end
    end

    // Cross-multiplied left-of-intercept test; sense flips for downward edges.
    always_comb begin
        for (int e = 0; e < 2; e++) begin
            c_tog[e] = r4_f[e].act && (r4_f[e].up ? (r4_p[e][0] < r4_p[e][1])
                                                  : (r4_p[e][0] > r4_p[e][1]));
        end
        c_flip = r_parity ^ c_tog[0] ^ c_tog[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (consume4) begin
                r_parity <= r4_last ? 1'b0 : c_flip;
            end
            if (out_rdy) begin
                r_out_valid <= r4_v && r4_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy && r4_v && r4_last) begin
            r_inside <= c_flip;
        end
    end

`ifndef NO_ASSERTIONS
    a_last_clears_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_is_last |=> !r_have_first)
        else $error("polygon state not cleared after last vertex");

    a_first_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_is_last |=> r_have_first)
        else $error("first vertex not recorded");

    a_blocked_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_v && r4_last && !out_rdy |=> r4_v && r4_last)
        else $error("result item lost while result register blocked");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r4_v && r4_last))
        else $error("result without a last vertex");
`endif

endmodule
